@@ sv/vtp_pkg.sv @@
// vtp_pkg.sv: shared constants, types and arithmetic helpers for the voxel texture packer.
// Depends on nothing; every other file of the block but vtp_delay imports it.
`default_nettype none

package vtp_pkg;

  localparam int SAMPLE_BITS_DEF = 16;

  // Stage counts of the pipeline sections
  localparam int FRONT_LAT   = 2;
  localparam int DIV_LAT     = 8;
  localparam int VAL_LAT     = 2 + DIV_LAT;
  localparam int NORM_LAT    = 16;
  localparam int SQRT_STAGES = 12;
  localparam int MAG_LAT     = 1 + SQRT_STAGES + 1 + DIV_LAT;
  localparam int PIPE_LAT    = FRONT_LAT + MAG_LAT;

  // 255 squared: scale of the normal and magnitude comparisons
  localparam logic [15:0] NORM_SCALE     = 16'd65025;
  localparam logic [7:0]  NORM_ZERO_BYTE = 8'd127;
  localparam logic [7:0]  BYTE_MAX       = 8'd255;

  typedef enum logic [1:0] {
    REG_VALUE_LOW,
    REG_VALUE_HIGH,
    REG_MAG_LOW,
    REG_MAG_HIGH
  } cfg_reg_t;

  typedef struct packed {
    logic zero;
    logic sat;
  } div_flags_t;

  typedef struct packed {
    logic [25:0] rem;
    logic [23:0] root;
  } sqrt_t;

  // One digit of the bitwise integer square root
  function automatic sqrt_t sqrt_step(sqrt_t x, logic [1:0] pair);
    logic [25:0] r;
    logic [25:0] trial;
    sqrt_t y;
    r     = {x.rem[23:0], pair};
    trial = {x.root, 2'b01};
    if (r >= trial) begin
      y.rem  = r - trial;
      y.root = {x.root[22:0], 1'b1};
    end else begin
      y.rem  = r;
      y.root = {x.root[22:0], 1'b0};
    end
    return y;
  endfunction

  // Square of |2c-255|, which is always odd and at most 255
  function automatic logic [15:0] odd_sq(logic [7:0] c);
    logic [7:0] m;
    m = c[7] ? {c[6:0], 1'b1} : ~{c[6:0], 1'b0};
    return {8'b0, m} * {8'b0, m};
  endfunction

endpackage

`default_nettype wire

@@ sv/vtp_delay.sv @@
// vtp_delay.sv: enabled shift register that aligns one pipeline branch with the longest one.
// Standalone; no package needed.
`default_nettype none

module vtp_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [DEPTH];

  // Advance all taps together with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

`default_nettype wire

@@ sv/vtp_div8.sv @@
// vtp_div8.sv: pipelined restoring divider giving an 8-bit quotient, one bit per stage.
// Depends on vtp_pkg (DIV_LAT, div_flags_t, BYTE_MAX).
`default_nettype none

module vtp_div8 import vtp_pkg::*; #(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W+7:0] num,
  input  logic [W-1:0] d,
  input  div_flags_t   flags,
  output logic [7:0]   q
);

  localparam int RW = W + 8;

  logic [RW-1:0] rem [DIV_LAT];
  logic [7:0]    qb  [DIV_LAT];
  div_flags_t    fl  [DIV_LAT];

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [RW-1:0] shifted;
    logic [RW-1:0] rem_next;
    logic [7:0]    q_in;
    logic [7:0]    q_next;
    div_flags_t    fl_in;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign q_in   = '0;
      assign fl_in  = flags;
    end else begin : g_chain
      assign rem_in = rem[i-1];
      assign q_in   = qb[i-1];
      assign fl_in  = fl[i-1];
    end

    // Try the shifted divisor for this quotient bit
    always_comb begin
      shifted  = RW'(d) << (DIV_LAT - 1 - i);
      ge       = rem_in >= shifted;
      rem_next = ge ? rem_in - shifted : rem_in;
      q_next   = q_in | (ge ? 8'(1 << (DIV_LAT - 1 - i)) : 8'd0);
    end

    // Hold on stall; the last stage applies the empty-window and saturation overrides
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= rem_next;
        fl[i]  <= fl_in;
        if (i == DIV_LAT - 1 && fl_in.zero) begin
          qb[i] <= '0;
        end else if (i == DIV_LAT - 1 && fl_in.sat) begin
          qb[i] <= BYTE_MAX;
        end else begin
          qb[i] <= q_next;
        end
      end
    end
  end

  assign q = qb[DIV_LAT-1];

endmodule

`default_nettype wire

@@ sv/vtp_value.sv @@
// vtp_value.sv: value window path: clamp, offset, scale by 255 and divide by the window span.
// Depends on vtp_pkg and vtp_div8.
`default_nettype none

module vtp_value import vtp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [SAMPLE_BITS-1:0] value_low,
  input  logic signed [SAMPLE_BITS-1:0] value_high,
  output logic [7:0]                    value_byte
);

  localparam int DW = SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] clamped;
  logic [DW-1:0]   span;
  logic [DW-1:0]   diff_next;
  logic [DW-1:0]   diff;
  logic [DW+7:0]   num;
  div_flags_t      fl1;
  div_flags_t      fl2;

  // Clamp to the window and take the offset from its low end
  always_comb begin
    clamped = sample;
    if (sample < value_low) begin
      clamped = value_low;
    end else if (sample > value_high) begin
      clamped = value_high;
    end
    diff_next = {clamped[SAMPLE_BITS-1], clamped} - {value_low[SAMPLE_BITS-1], value_low};
    span      = {value_high[SAMPLE_BITS-1], value_high} - {value_low[SAMPLE_BITS-1], value_low};
  end

  // Offset stage, then times 255 as shift and subtract
  always_ff @(posedge clk) begin
    if (en) begin
      diff     <= diff_next;
      fl1.zero <= !(value_high > value_low);
      fl1.sat  <= 1'b0;
      num      <= {diff, 8'b0} - {8'b0, diff};
      fl2      <= fl1;
    end
  end

  vtp_div8 #(.W(DW)) u_div (
    .clk   (clk),
    .en    (en),
    .num   (num),
    .d     (span),
    .flags (fl2),
    .q     (value_byte)
  );

endmodule

`default_nettype wire

@@ sv/vtp_mag.sv @@
// vtp_mag.sv: gradient length path: scale by 255^2, pipelined square root, window and divide.
// Depends on vtp_pkg (sqrt_step, sqrt_t) and vtp_div8.
`default_nettype none

module vtp_mag import vtp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] s,
  input  logic [15:0] magnitude_low,
  input  logic [15:0] magnitude_high,
  output logic [7:0]  magnitude_byte
);

  logic [47:0] n0;
  logic [47:0] sn [SQRT_STAGES];
  sqrt_t       st [SQRT_STAGES];

  logic [23:0] root;
  logic [23:0] base;
  logic [15:0] span;
  logic [23:0] diff_next;
  logic [23:0] diff;
  div_flags_t  fl_next;
  div_flags_t  fl;

  // Radicand 65025 * sum of squares
  always_ff @(posedge clk) begin
    if (en) begin
      n0 <= {16'b0, s} * {32'b0, NORM_SCALE};
    end
  end

  // Two root digits per stage
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    logic [47:0] n_in;
    sqrt_t       st_in;

    if (j == 0) begin : g_first
      assign n_in  = n0;
      assign st_in = '0;
    end else begin : g_chain
      assign n_in  = sn[j-1];
      assign st_in = st[j-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sn[j] <= n_in;
        st[j] <= sqrt_step(sqrt_step(st_in, n_in[47-4*j -: 2]), n_in[45-4*j -: 2]);
      end
    end
  end

  assign root = st[SQRT_STAGES-1].root;

  // Offset by 255 * low end, flag an empty window or a root at or below the low end, and overflow past 255
  always_comb begin
    base         = {magnitude_low, 8'b0} - {8'b0, magnitude_low};
    span         = magnitude_high - magnitude_low;
    diff_next    = root - base;
    fl_next.zero = !(magnitude_high > magnitude_low) || !(root > base);
    fl_next.sat  = diff_next >= {span, 8'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff <= diff_next;
      fl   <= fl_next;
    end
  end

  vtp_div8 #(.W(16)) u_div (
    .clk   (clk),
    .en    (en),
    .num   (diff),
    .d     (span),
    .flags (fl),
    .q     (magnitude_byte)
  );

endmodule

`default_nettype wire

@@ sv/vtp_normal.sv @@
// vtp_normal.sv: one normal byte by bitwise search, comparing (2k-255)^2*S with 65025*g^2.
// Depends on vtp_pkg (odd_sq, NORM_ZERO_BYTE).
`default_nettype none

module vtp_normal import vtp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] s,
  input  logic [46:0] g2,
  input  logic        neg,
  output logic [7:0]  normal_byte
);

  // Multiply stage registers
  logic [7:0]  m_k    [8];
  logic [7:0]  m_cand [8];
  logic [47:0] m_p    [8];
  logic [15:0] m_sq0  [8];
  logic [15:0] m_sq1  [8];
  logic [31:0] m_s    [8];
  logic [46:0] m_g2   [8];
  logic        m_neg  [8];
  logic        m_zero [8];

  // Compare stage registers
  logic [7:0]  c_k    [8];
  logic [7:0]  c_cand [8];
  logic [15:0] c_a2   [8];
  logic [31:0] c_s    [8];
  logic [46:0] c_g2   [8];
  logic        c_neg  [8];
  logic        c_zero [8];

  for (genvar i = 0; i < 8; i++) begin : g_bit
    localparam logic [7:0] NB = 8'(8'd64 >> i);

    logic [7:0]  k_in;
    logic [7:0]  cand_in;
    logic [15:0] a2_in;
    logic [31:0] s_in;
    logic [46:0] g2_in;
    logic        neg_in;
    logic        zero_in;
    logic        ok;
    logic [7:0]  k_next;

    if (i == 0) begin : g_first
      assign k_in    = '0;
      assign cand_in = 8'd128;
      assign a2_in   = 16'd1;
      assign s_in    = s;
      assign g2_in   = g2;
      assign neg_in  = neg;
      assign zero_in = (s == 32'd0);
    end else begin : g_chain
      assign k_in    = c_k[i-1];
      assign cand_in = c_cand[i-1];
      assign a2_in   = c_a2[i-1];
      assign s_in    = c_s[i-1];
      assign g2_in   = c_g2[i-1];
      assign neg_in  = c_neg[i-1];
      assign zero_in = c_zero[i-1];
    end

    // Multiply the candidate's square by S; square both possible next candidates
    always_ff @(posedge clk) begin
      if (en) begin
        m_k[i]    <= k_in;
        m_cand[i] <= cand_in;
        m_p[i]    <= {32'b0, a2_in} * {16'b0, s_in};
        m_sq0[i]  <= odd_sq(k_in | NB);
        m_sq1[i]  <= odd_sq(cand_in | NB);
        m_s[i]    <= s_in;
        m_g2[i]   <= g2_in;
        m_neg[i]  <= neg_in;
        m_zero[i] <= zero_in;
      end
    end

    // Keep the candidate when (2k-255)*|grad| <= 255*g holds
    always_comb begin
      if (m_cand[i][7]) begin
        ok = !m_neg[i] && (m_p[i] <= {1'b0, m_g2[i]});
      end else begin
        ok = !m_neg[i] || (m_p[i] >= {1'b0, m_g2[i]});
      end
      k_next = ok ? m_cand[i] : m_k[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c_cand[i] <= k_next | NB;
        c_a2[i]   <= ok ? m_sq1[i] : m_sq0[i];
        c_s[i]    <= m_s[i];
        c_g2[i]   <= m_g2[i];
        c_neg[i]  <= m_neg[i];
        c_zero[i] <= m_zero[i];
        if (i == 7 && m_zero[i]) begin
          c_k[i] <= NORM_ZERO_BYTE;
        end else begin
          c_k[i] <= k_next;
        end
      end
    end
  end

  assign normal_byte = c_k[7];

endmodule

`default_nettype wire

@@ sv/voxel_texture_packer.sv @@
// Voxel texture packer: one voxel in, five texture bytes out.
// The 24-digit gradient-length square root (12 stages) and the 8-stage quotient divider
// of the magnitude path set the depth from input transfer to result.
// Throughput: one voxel per cycle while the result side takes; a stalled result holds the
// whole pipeline. Reset (rst, synchronous) empties the pipeline and loads the windows with
// value 0..1 and magnitude 0..1. Depends on vtp_pkg and all vtp_ units but vtp_checker.
`default_nettype none

module voxel_texture_packer import vtp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CFG_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic signed [15:0]            grad_x,
  input  logic signed [15:0]            grad_y,
  input  logic signed [15:0]            grad_z,
  input  logic                          last_voxel,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [7:0]                    value_byte,
  output logic [7:0]                    normal_x_byte,
  output logic [7:0]                    normal_y_byte,
  output logic [7:0]                    normal_z_byte,
  output logic [7:0]                    magnitude_byte,
  output logic                          last_out,
  input  logic                          cfg_write,
  input  logic [1:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  logic signed [SAMPLE_BITS-1:0] value_low;
  logic signed [SAMPLE_BITS-1:0] value_high;
  logic [15:0] magnitude_low;
  logic [15:0] magnitude_high;

  logic [PIPE_LAT-1:0] vld;
  logic en;

  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [31:0] pz;
  logic [30:0] sqx;
  logic [30:0] sqy;
  logic [30:0] sqz;
  logic [2:0]  neg1;
  logic [2:0]  neg2;
  logic [31:0] ssum;
  logic [46:0] g2x;
  logic [46:0] g2y;
  logic [46:0] g2z;

  logic [7:0]  val_raw;
  logic [7:0]  nx_raw;
  logic [7:0]  ny_raw;
  logic [7:0]  nz_raw;
  logic [23:0] normals;

  // Window registers
  always_ff @(posedge clk) begin
    if (rst) begin
      value_low      <= '0;
      value_high     <= SAMPLE_BITS'(1);
      magnitude_low  <= '0;
      magnitude_high <= 16'd1;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_VALUE_LOW:  value_low      <= cfg_data[SAMPLE_BITS-1:0];
        REG_VALUE_HIGH: value_high     <= cfg_data[SAMPLE_BITS-1:0];
        REG_MAG_LOW:    magnitude_low  <= cfg_data[15:0];
        REG_MAG_HIGH:   magnitude_high <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Advance the whole pipeline unless a finished result waits
  assign en           = !vld[PIPE_LAT-1] || result_ready;
  assign item_ready   = en;
  assign result_valid = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], item_valid};
    end
  end

  // Front: component squares, then their sum and the 65025-scaled squares
  assign px = grad_x * grad_x;
  assign py = grad_y * grad_y;
  assign pz = grad_z * grad_z;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx  <= px[30:0];
      sqy  <= py[30:0];
      sqz  <= pz[30:0];
      neg1 <= {grad_z[15], grad_y[15], grad_x[15]};
      ssum <= {1'b0, sqx} + {1'b0, sqy} + {1'b0, sqz};
      g2x  <= {16'b0, sqx} * {31'b0, NORM_SCALE};
      g2y  <= {16'b0, sqy} * {31'b0, NORM_SCALE};
      g2z  <= {16'b0, sqz} * {31'b0, NORM_SCALE};
      neg2 <= neg1;
    end
  end

  vtp_value #(.SAMPLE_BITS(SAMPLE_BITS)) u_value (
    .clk        (clk),
    .en         (en),
    .sample     (sample),
    .value_low  (value_low),
    .value_high (value_high),
    .value_byte (val_raw)
  );

  vtp_normal u_nx (
    .clk (clk), .en (en), .s (ssum), .g2 (g2x), .neg (neg2[0]), .normal_byte (nx_raw)
  );

  vtp_normal u_ny (
    .clk (clk), .en (en), .s (ssum), .g2 (g2y), .neg (neg2[1]), .normal_byte (ny_raw)
  );

  vtp_normal u_nz (
    .clk (clk), .en (en), .s (ssum), .g2 (g2z), .neg (neg2[2]), .normal_byte (nz_raw)
  );

  vtp_mag u_mag (
    .clk            (clk),
    .en             (en),
    .s              (ssum),
    .magnitude_low  (magnitude_low),
    .magnitude_high (magnitude_high),
    .magnitude_byte (magnitude_byte)
  );

  // Align the shorter branches with the magnitude path
  vtp_delay #(.W(8), .DEPTH(PIPE_LAT - VAL_LAT)) u_val_dly (
    .clk (clk), .en (en), .d (val_raw), .q (value_byte)
  );

  vtp_delay #(.W(24), .DEPTH(PIPE_LAT - FRONT_LAT - NORM_LAT)) u_norm_dly (
    .clk (clk), .en (en), .d ({nz_raw, ny_raw, nx_raw}), .q (normals)
  );

  vtp_delay #(.W(1), .DEPTH(PIPE_LAT)) u_last_dly (
    .clk (clk), .en (en), .d (last_voxel), .q (last_out)
  );

  assign normal_x_byte = normals[7:0];
  assign normal_y_byte = normals[15:8];
  assign normal_z_byte = normals[23:16];

endmodule

`default_nettype wire

@@ sv/vtp_checker.sv @@
// vtp_checker.sv: port-level checks of the voxel texture packer, bound to the top level.
// Depends on vtp_pkg for the default sample width.
`default_nettype none

module vtp_checker import vtp_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int CFG_W = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic signed [SAMPLE_BITS-1:0] sample,
  input logic signed [15:0]            grad_x,
  input logic signed [15:0]            grad_y,
  input logic signed [15:0]            grad_z,
  input logic                          last_voxel,
  input logic                          result_valid,
  input logic                          result_ready,
  input logic [7:0]                    value_byte,
  input logic [7:0]                    normal_x_byte,
  input logic [7:0]                    normal_y_byte,
  input logic [7:0]                    normal_z_byte,
  input logic [7:0]                    magnitude_byte,
  input logic                          last_out,
  input logic                          cfg_write,
  input logic [1:0]                    cfg_index,
  input logic [CFG_W-1:0]              cfg_data
);

  // A waiting result stays offered
  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before transfer");

  // A waiting result keeps its bytes
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> $stable(value_byte) && $stable(normal_x_byte)
      && $stable(normal_y_byte) && $stable(normal_z_byte) && $stable(magnitude_byte)
      && $stable(last_out))
    else $error("waiting result changed");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered right after reset");

  // Input is only held back by a result that is not being taken
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (!result_valid || result_ready) |-> item_ready)
    else $error("input stalled with a free output");

endmodule

bind voxel_texture_packer vtp_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_vtp_checker (.*);

`default_nettype wire
